@@ hw/rtl/iepc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iepc_pkg
// Shared types and constants for the ICMP echo parse and checksum block.
// ----------------------------------------------------------------------------
package iepc_pkg;

  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned HDR_POS_W    = $clog2(HEADER_BYTES);
  localparam int unsigned COUNT_W      = 16;

  localparam logic [7:0] TYPE_ECHO_REQUEST = 8'd8;
  localparam logic [7:0] TYPE_ECHO_REPLY   = 8'd0;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SHORT    = 2'd1,
    STATUS_BAD_TYPE = 2'd2,
    STATUS_BAD_SUM  = 2'd3
  } status_t;

  typedef struct packed {
    status_t              status;
    logic [7:0]           msg_type;
    logic [7:0]           msg_code;
    logic [15:0]          identifier;
    logic [15:0]          sequence_number;
    logic [15:0]          checksum_field;
    logic [COUNT_W-1:0]   payload_length;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } result_beat_t;

endpackage : iepc_pkg
`default_nettype wire

@@ hw/rtl/iepc_accum.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iepc_accum
// Input register, header capture, byte count and ones'-complement sum.
// Builds the result beat on the last byte of a message.
// ----------------------------------------------------------------------------
module iepc_accum
  import iepc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic         in_stall,
  input  wire logic [7:0]   in_data_byte,
  input  wire logic         in_last_byte,
  output result_beat_t      res,
  output logic              pend_last
);

  localparam logic [HDR_POS_W-1:0] POS_TYPE   = HDR_POS_W'(0);
  localparam logic [HDR_POS_W-1:0] POS_CODE   = HDR_POS_W'(1);
  localparam logic [HDR_POS_W-1:0] POS_CSUM_H = HDR_POS_W'(2);
  localparam logic [HDR_POS_W-1:0] POS_CSUM_L = HDR_POS_W'(3);
  localparam logic [HDR_POS_W-1:0] POS_ID_H   = HDR_POS_W'(4);
  localparam logic [HDR_POS_W-1:0] POS_ID_L   = HDR_POS_W'(5);
  localparam logic [HDR_POS_W-1:0] POS_SEQ_H  = HDR_POS_W'(6);
  localparam logic [HDR_POS_W-1:0] POS_SEQ_L  = HDR_POS_W'(7);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] HDR_LEN   = COUNT_W'(HEADER_BYTES);

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'b0, s[16]};
  endfunction

  logic               s1_valid_r;
  logic [7:0]         s1_byte_r;
  logic               s1_last_r;

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [15:0]        sum_r, sum_nxt;
  logic [7:0]         held_r, held_nxt;
  logic               odd_r, odd_nxt;
  logic [7:0]         type_r, type_nxt;
  logic [7:0]         code_r, code_nxt;
  logic [15:0]        csum_r, csum_nxt;
  logic [15:0]        id_r, id_nxt;
  logic [15:0]        seq_r, seq_nxt;

  logic [15:0]        word;
  logic [15:0]        sum_add;
  result_t            rslt;

  always_comb begin
    type_nxt = type_r;
    code_nxt = code_r;
    csum_nxt = csum_r;
    id_nxt   = id_r;
    seq_nxt  = seq_r;
    if (count_r < HDR_LEN) begin
      unique case (count_r[HDR_POS_W-1:0])
        POS_TYPE:   type_nxt       = s1_byte_r;
        POS_CODE:   code_nxt       = s1_byte_r;
        POS_CSUM_H: csum_nxt[15:8] = s1_byte_r;
        POS_CSUM_L: csum_nxt[7:0]  = s1_byte_r;
        POS_ID_H:   id_nxt[15:8]   = s1_byte_r;
        POS_ID_L:   id_nxt[7:0]    = s1_byte_r;
        POS_SEQ_H:  seq_nxt[15:8]  = s1_byte_r;
        POS_SEQ_L:  seq_nxt[7:0]   = s1_byte_r;
      endcase
    end

    word      = odd_r ? {held_r, s1_byte_r} : {s1_byte_r, 8'h00};
    sum_add   = ones_add(sum_r, word);
    count_nxt = (count_r == COUNT_MAX) ? count_r : count_r + COUNT_W'(1);
    sum_nxt   = odd_r ? sum_add : sum_r;
    held_nxt  = odd_r ? held_r : s1_byte_r;
    odd_nxt   = !odd_r;

    rslt.msg_type        = type_nxt;
    rslt.msg_code        = code_nxt;
    rslt.identifier      = id_nxt;
    rslt.sequence_number = seq_nxt;
    rslt.checksum_field  = csum_nxt;
    rslt.payload_length  = '0;
    priority if (count_nxt < HDR_LEN) begin
      rslt.status = STATUS_SHORT;
    end else if (type_nxt != TYPE_ECHO_REQUEST && type_nxt != TYPE_ECHO_REPLY) begin
      rslt.status         = STATUS_BAD_TYPE;
      rslt.payload_length = count_nxt - HDR_LEN;
    end else if (sum_add != 16'hFFFF) begin
      rslt.status         = STATUS_BAD_SUM;
      rslt.payload_length = count_nxt - HDR_LEN;
    end else begin
      rslt.status         = STATUS_OK;
      rslt.payload_length = count_nxt - HDR_LEN;
    end
  end

  assign res.valid = s1_valid_r && s1_last_r;
  assign res.data  = rslt;
  assign pend_last = s1_valid_r && s1_last_r;

  always_ff @(posedge clk) begin
    s1_byte_r <= in_data_byte;
    s1_last_r <= in_last_byte;
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      count_r    <= '0;
      sum_r      <= '0;
      held_r     <= '0;
      odd_r      <= 1'b0;
      type_r     <= '0;
      code_r     <= '0;
      csum_r     <= '0;
      id_r       <= '0;
      seq_r      <= '0;
    end else begin
      s1_valid_r <= in_valid && !in_stall;
      if (s1_valid_r) begin
        if (s1_last_r) begin
          count_r <= '0;
          sum_r   <= '0;
          held_r  <= '0;
          odd_r   <= 1'b0;
          type_r  <= '0;
          code_r  <= '0;
          csum_r  <= '0;
          id_r    <= '0;
          seq_r   <= '0;
        end else begin
          count_r <= count_nxt;
          sum_r   <= sum_nxt;
          held_r  <= held_nxt;
          odd_r   <= odd_nxt;
          type_r  <= type_nxt;
          code_r  <= code_nxt;
          csum_r  <= csum_nxt;
          id_r    <= id_nxt;
          seq_r   <= seq_nxt;
        end
      end
    end
  end

endmodule : iepc_accum
`default_nettype wire

@@ hw/rtl/iepc_outbuf.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iepc_outbuf
// Result register with a skid entry; drives the input stall.
// ----------------------------------------------------------------------------
module iepc_outbuf
  import iepc_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire result_beat_t  res,
  input  wire logic          pend_last,
  input  wire logic          out_stall,
  output logic               in_stall,
  output logic               out_valid,
  output result_t            out_data
);

  logic    out_valid_r, out_valid_nxt;
  result_t out_data_r, out_data_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t skid_data_r, skid_data_nxt;
  logic    taken;

  assign taken    = out_valid_r && !out_stall;
  assign in_stall = skid_valid_r || (pend_last && out_valid_r && out_stall);

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    priority if (!out_valid_r || taken) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res.valid;
        out_data_nxt  = res.data;
      end
    end else if (res.valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res.data;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule : iepc_outbuf
`default_nettype wire

@@ hw/rtl/icmp_echo_parse_check_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// icmp_echo_parse_check_core
// Streaming ICMP echo header parser with Internet checksum check.
//
//   channel  direction  beat                         handshake
//   in_      sink       one message byte + last mark in_valid / in_stall
//   out_     source     one verdict per message      out_valid / out_stall
//
// One byte beat is taken every cycle while in_stall is low. The verdict is
// built from the input register and held in the result register. Reset
// clears the running count, sum and captured header. A skid entry behind the
// result register keeps bytes flowing while a verdict waits; in_stall rises
// only when the skid entry is in use or a verdict is about to need it.
// ----------------------------------------------------------------------------
module icmp_echo_parse_check_core
  import iepc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [7:0]       out_msg_type,
  output logic [7:0]       out_msg_code,
  output logic [15:0]      out_identifier,
  output logic [15:0]      out_sequence_number,
  output logic [15:0]      out_checksum_field,
  output logic [15:0]      out_payload_length
);

  result_beat_t res;
  logic         pend_last;
  result_t      out_data;

  iepc_accum u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .res          (res),
    .pend_last    (pend_last)
  );

  iepc_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .pend_last (pend_last),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign out_status          = out_data.status;
  assign out_msg_type        = out_data.msg_type;
  assign out_msg_code        = out_data.msg_code;
  assign out_identifier      = out_data.identifier;
  assign out_sequence_number = out_data.sequence_number;
  assign out_checksum_field  = out_data.checksum_field;
  assign out_payload_length  = out_data.payload_length;

endmodule : icmp_echo_parse_check_core
`default_nettype wire
